@@ rtl/spq_pkg.sv @@
// spq_pkg: shared types, codes and constants of the sorted priority queue
// no dependencies; imported by every other file of the block
`default_nettype none

package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int PRI_W        = 32;
  localparam int ENTRY_W      = VAL_W + PRI_W;
  localparam int CNT_OUT_W    = 5;
  localparam int STATUS_W     = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_CMP,
    S_HEAD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    scan_init;
    logic    scan_dec;
    logic    rd_prev;
    logic    rd_head;
    logic    wr_new;
    logic    wr_shift;
    logic    base_inc;
    logic    count_inc;
    logic    count_dec;
    logic    status_set;
    status_t status_val;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic req_deq;
    logic full;
    logic empty;
    logic scan_zero;
    logic new_greater;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/spq_in_if.sv @@
// spq_in_if: request channel (enqueue or dequeue) with valid/ready handshake
// depends on spq_pkg for field widths
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [VAL_W-1:0] element_value;
  logic signed [PRI_W-1:0] priority_req;

  modport source (output valid, kind, element_value, priority_req, input ready);
  modport sink   (input valid, kind, element_value, priority_req, output ready);
endinterface

`default_nettype wire

@@ rtl/spq_out_if.sv @@
// spq_out_if: result channel (head entry, count, flags) with valid/ready handshake
// depends on spq_pkg for field widths
`default_nettype none

interface spq_out_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] head_value;
  logic signed [PRI_W-1:0] head_priority;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic                    is_empty;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, head_value, head_priority, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, head_value, head_priority, entry_count, is_empty, status,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
// spq_ctrl: sequencing state machine of the sorted priority queue
// depends on spq_pkg; drives the datapath commands and both handshakes
`default_nettype none

module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t       cmd
);
  import spq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!stat.req_deq && !stat.full) state_nxt = S_SCAN;
        else                             state_nxt = S_HEAD;
      end
      S_SCAN:   state_nxt = stat.scan_zero ? S_HEAD : S_CMP;
      S_CMP:    state_nxt = stat.new_greater ? S_SCAN : S_HEAD;
      S_HEAD:   state_nxt = S_RESULT;
      S_RESULT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_DECIDE: begin
        cmd.status_set = 1'b1;
        cmd.status_val = ST_OK;
        if (stat.req_deq) begin
          if (stat.empty) begin
            cmd.status_val = ST_EMPTY;
          end else begin
            cmd.base_inc  = 1'b1;
            cmd.count_dec = 1'b1;
          end
        end else begin
          if (stat.full) cmd.status_val = ST_FULL;
          else           cmd.scan_init  = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.scan_zero) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
        end else begin
          cmd.rd_prev = 1'b1;
        end
      end
      S_CMP: begin
        if (stat.new_greater) begin
          cmd.wr_shift = 1'b1;
          cmd.scan_dec = 1'b1;
        end else begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
        end
      end
      S_HEAD:   cmd.rd_head  = 1'b1;
      S_RESULT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

endmodule

`default_nettype wire

@@ rtl/spq_dp.sv @@
// spq_dp: datapath of the sorted priority queue: circular entry memory,
// head pointer, count, insertion scan index and result register; uses spq_pkg
`default_nettype none

module spq_dp #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire spq_pkg::dp_cmd_t                 cmd,
  output spq_pkg::dp_stat_t                     stat,
  input  wire logic                             in_kind,
  input  wire logic signed [spq_pkg::VAL_W-1:0] in_element_value,
  input  wire logic signed [spq_pkg::PRI_W-1:0] in_priority_req,
  output logic signed [spq_pkg::VAL_W-1:0]      out_head_value,
  output logic signed [spq_pkg::PRI_W-1:0]      out_head_priority,
  output logic [spq_pkg::CNT_OUT_W-1:0]         out_entry_count,
  output logic                                  out_is_empty,
  output logic [spq_pkg::STATUS_W-1:0]          out_status
);
  import spq_pkg::*;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int EXT_W  = CNT_W + CNT_OUT_W;
  localparam logic [ADDR_W:0]   CAP_A  = (ADDR_W + 1)'(CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);

  logic [ENTRY_W-1:0] mem [CAPACITY];

  logic                    kind_r;
  logic [VAL_W-1:0]        val_r;
  logic signed [PRI_W-1:0] pri_r;
  logic [ADDR_W-1:0]       base_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        idx_r;
  status_t                 status_r;
  logic [ENTRY_W-1:0]      rd_q_r;

  logic                    mem_re, mem_we;
  logic [CNT_W-1:0]        idx_prev;
  logic [ADDR_W-1:0]       rd_la, rd_pa, wr_pa;
  logic [ADDR_W:0]         rd_sum, wr_sum;
  logic [ENTRY_W-1:0]      wr_data;
  logic signed [PRI_W-1:0] rd_pri;
  logic [EXT_W-1:0]        count_ext;

  assign idx_prev = idx_r - CNT_W'(1);
  assign rd_la    = cmd.rd_prev ? idx_prev[ADDR_W-1:0] : '0;
  assign rd_sum   = {1'b0, base_r} + {1'b0, rd_la};
  assign rd_pa    = (rd_sum >= CAP_A) ? ADDR_W'(rd_sum - CAP_A) : rd_sum[ADDR_W-1:0];
  assign wr_sum   = {1'b0, base_r} + {1'b0, idx_r[ADDR_W-1:0]};
  assign wr_pa    = (wr_sum >= CAP_A) ? ADDR_W'(wr_sum - CAP_A) : wr_sum[ADDR_W-1:0];
  assign mem_re   = cmd.rd_prev || cmd.rd_head;
  assign mem_we   = cmd.wr_new || cmd.wr_shift;
  assign wr_data  = cmd.wr_shift ? rd_q_r : {pri_r, val_r};
  assign rd_pri   = rd_q_r[ENTRY_W-1:VAL_W];

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_pa] <= wr_data;
    if (mem_re) rd_q_r <= mem[rd_pa];
  end

  assign stat.req_deq     = (kind_r == KIND_DEQ);
  assign stat.full        = (count_r >= CAP_C);
  assign stat.empty       = (count_r == '0);
  assign stat.scan_zero   = (idx_r == '0);
  assign stat.new_greater = (pri_r > rd_pri);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.base_inc)       base_r  <= (base_r == LAST_A) ? '0 : base_r + ADDR_W'(1);
      if (cmd.count_inc)      count_r <= count_r + CNT_W'(1);
      else if (cmd.count_dec) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r <= in_kind;
      val_r  <= in_element_value;
      pri_r  <= in_priority_req;
    end
    if (cmd.scan_init)     idx_r <= count_r;
    else if (cmd.scan_dec) idx_r <= idx_prev;
    if (cmd.status_set) status_r <= cmd.status_val;
  end

  assign count_ext = EXT_W'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry_count <= count_ext[CNT_OUT_W-1:0];
      out_is_empty    <= (count_r == '0);
      out_status      <= status_r;
      if (count_r == '0) begin
        out_head_value    <= '0;
        out_head_priority <= '0;
      end else begin
        out_head_value    <= rd_q_r[VAL_W-1:0];
        out_head_priority <= rd_pri;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// sorted_priority_queue: bounded priority queue, highest priority first, ties in arrival order
// a request is accepted only while no other is in progress; a dequeue or rejected request then
// reads the head, an enqueue first moves each stored entry of lower priority back and writes
// the new entry; the result waits while the result side stalls, and only then is a new one taken
// reset (rst_n, synchronous): queue empty, no result pending; memory contents are not cleared
// depends on spq_pkg, spq_in_if, spq_out_if, spq_ctrl, spq_dp
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_chan,
  spq_out_if.source  out_chan
);
  import spq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_chan.kind),
    .in_element_value  (in_chan.element_value),
    .in_priority_req   (in_chan.priority_req),
    .out_head_value    (out_chan.head_value),
    .out_head_priority (out_chan.head_priority),
    .out_entry_count   (out_chan.entry_count),
    .out_is_empty      (out_chan.is_empty),
    .out_status        (out_chan.status)
  );

endmodule

`default_nettype wire

@@ rtl/spq_checker.sv @@
// spq_checker: port-level assertions on the result channel of sorted_priority_queue
// depends on spq_pkg; attached to the top level by the bind statement below
`default_nettype none

module spq_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [spq_pkg::VAL_W-1:0] head_value,
  input wire logic signed [spq_pkg::PRI_W-1:0] head_priority,
  input wire logic [spq_pkg::CNT_OUT_W-1:0]    entry_count,
  input wire logic                             is_empty,
  input wire logic [spq_pkg::STATUS_W-1:0]     status
);
  import spq_pkg::*;

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(head_value) &&
      $stable(head_priority) && $stable(entry_count) && $stable(status))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> head_value == '0 && head_priority == '0 && entry_count == '0)
    else $error("empty result with nonzero head or count");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> !is_empty)
    else $error("full drop reported on an empty queue");

  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> is_empty)
    else $error("empty dequeue reported with entries stored");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_OK || status == ST_FULL || status == ST_EMPTY)
    else $error("undefined status code");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .head_value    (out_chan.head_value),
  .head_priority (out_chan.head_priority),
  .entry_count   (out_chan.entry_count),
  .is_empty      (out_chan.is_empty),
  .status        (out_chan.status)
);

`default_nettype wire

@@ dv/sorted_priority_queue_test.sv @@
// sorted_priority_queue_test: self-checking testbench for the sorted priority queue
// holds its own model of the queue, a request driver, a result checker and a watchdog
// depends on spq_pkg, spq_in_if, spq_out_if and the sorted_priority_queue rtl

module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 60;
  localparam int HOLD_AFTER   = 120;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } request_t;

  typedef struct {
    logic signed [VAL_W-1:0] head_value;
    logic signed [PRI_W-1:0] head_prio;
    logic [CNT_OUT_W-1:0]    count;
    logic                    empty;
    status_t                 status;
  } head_report_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_chan ();
  spq_out_if out_chan ();

  sorted_priority_queue #(.CAPACITY(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  request_t     pending_reqs[$];
  head_report_t expected_heads[$];

  logic signed [VAL_W-1:0] model_vals [DEPTH];
  logic signed [PRI_W-1:0] model_pris [DEPTH];
  int unsigned             model_len;

  int  fail_count;
  int  idle_cycles;
  logic in_taken;
  logic out_taken;
  int  in_gap;
  int  out_gap;
  bit  in_burst;
  bit  out_burst;
  int  results_seen;
  int  hold_left;

  always #5 clk = ~clk;

  // new entry goes behind every stored entry of equal or higher priority
  function automatic head_report_t queue_apply(request_t req);
    head_report_t rep;
    int unsigned  pos;
    rep.status = ST_OK;
    if (req.kind == KIND_ENQ) begin
      if (model_len >= DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < model_len && !(req.prio > model_pris[pos])) pos++;
        for (int unsigned i = model_len; i > pos; i--) begin
          model_vals[i] = model_vals[i-1];
          model_pris[i] = model_pris[i-1];
        end
        model_vals[pos] = req.value;
        model_pris[pos] = req.prio;
        model_len++;
      end
    end else begin
      if (model_len == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        for (int unsigned i = 1; i < model_len; i++) begin
          model_vals[i-1] = model_vals[i];
          model_pris[i-1] = model_pris[i];
        end
        model_len--;
      end
    end
    rep.head_value = (model_len == 0) ? '0 : model_vals[0];
    rep.head_prio  = (model_len == 0) ? '0 : model_pris[0];
    rep.count      = model_len[CNT_OUT_W-1:0];
    rep.empty      = (model_len == 0);
    return rep;
  endfunction

  function automatic void check_field(string field, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  function automatic int next_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic add_request(logic kind, logic signed [VAL_W-1:0] value,
                             logic signed [PRI_W-1:0] prio);
    request_t req;
    req.kind  = kind;
    req.value = value;
    req.prio  = prio;
    pending_reqs.push_back(req);
  endtask

  always @(posedge clk) begin : sample_edge
    head_report_t want;
    request_t     req;
    in_taken  <= rst_n && in_chan.valid && in_chan.ready;
    out_taken <= rst_n && out_chan.valid && out_chan.ready;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_heads.size() == 0) begin
        $error("unexpected result transaction: head_value %0d, entry_count %0d",
               out_chan.head_value, out_chan.entry_count);
        fail_count++;
      end else begin
        want = expected_heads.pop_front();
        check_field("head_value", want.head_value, out_chan.head_value);
        check_field("head_priority", want.head_prio, out_chan.head_priority);
        check_field("entry_count", want.count, out_chan.entry_count);
        check_field("is_empty", want.empty, out_chan.is_empty);
        check_field("status", want.status, out_chan.status);
      end
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      req.kind  = in_chan.kind;
      req.value = in_chan.element_value;
      req.prio  = in_chan.priority_req;
      expected_heads.push_back(queue_apply(req));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** sorted_priority_queue: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin : drive_requests
    request_t req;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_chan.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        in_chan.kind          <= req.kind;
        in_chan.element_value <= req.value;
        in_chan.priority_req  <= req.prio;
        in_chan.valid         <= 1'b1;
        in_gap = next_gap(in_burst);
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // one long hold-off lets the queue back up and stall the request side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        results_seen++;
        out_gap = next_gap(out_burst);
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    int                      mode;
    int                      span;
    int                      enq_pct;
    int                      made;
    logic                    kind;
    logic signed [PRI_W-1:0] prio;

    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.kind          = KIND_ENQ;
    in_chan.element_value = '0;
    in_chan.priority_req  = '0;
    out_chan.ready        = 1'b0;

    // dequeue on empty, extremes, ties, fill to capacity, overflow, then drain a few
    add_request(KIND_DEQ, 32'shffffffff, 32'shffffffff);
    add_request(KIND_ENQ, 32'sh7fffffff, 32'sh7fffffff);
    add_request(KIND_ENQ, 32'sh80000000, 32'sh80000000);
    add_request(KIND_ENQ, 32'sh00000000, 32'sh00000000);
    add_request(KIND_ENQ, -32'sd1, -32'sd1);
    add_request(KIND_ENQ, 32'sd11, 32'sd5);
    add_request(KIND_ENQ, 32'sd12, 32'sd5);
    add_request(KIND_ENQ, 32'sd13, 32'sd5);
    add_request(KIND_ENQ, 32'sd21, 32'sh7fffffff);
    add_request(KIND_ENQ, 32'sd22, 32'sh80000000);
    for (int i = 10; i < DEPTH + 1; i++) add_request(KIND_ENQ, 100 + i, i - 12);
    add_request(KIND_ENQ, 32'sd999, 32'sh7fffffff);
    repeat (5) add_request(KIND_DEQ, 32'sh00000000, 32'sh00000000);

    // phases biased towards filling, draining or a balanced mix
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 2);
      span    = $urandom_range(8, 40);
      enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      for (int k = 0; k < span && made < RANDOM_ITEMS; k++) begin
        kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        case ($urandom_range(0, 9))
          0: prio = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
          1, 2: prio = $urandom;
          default: prio = $urandom_range(0, 6) - 3;
        endcase
        add_request(kind, $urandom, prio);
        made++;
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_reqs.size() > 0 || in_chan.valid);
    while (expected_heads.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/sorted_priority_queue_test.sv
